### hdl/sorted_unique_key_set_macros.svh
// Assertion macros for the sorted unique key set.
`ifndef SORTED_UNIQUE_KEY_SET_MACROS_SVH
`define SORTED_UNIQUE_KEY_SET_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SUKS_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SUKS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### hdl/suks_pkg.sv
// Shared types, codes and defaults for the sorted unique key set.
package suks_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int SCAN_LANES    = 32;

  localparam int IN_KEY_W  = 32;
  localparam int OUT_KEY_W = 32;
  localparam int COUNT_W   = 7;

  localparam logic [1:0] ACT_INSERT    = 2'd0;
  localparam logic [1:0] ACT_EXTRACT   = 2'd1;
  localparam logic [1:0] ACT_CLEAR     = 2'd2;
  localparam logic [1:0] ACT_CLEAR_ALT = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EXTRACTED = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  typedef logic [1:0] cell_op_t;

  localparam cell_op_t CELL_HOLD = 2'd0;
  localparam cell_op_t CELL_CMP  = 2'd1;
  localparam cell_op_t CELL_INS  = 2'd2;
  localparam cell_op_t CELL_POP  = 2'd3;

  typedef struct packed {
    logic done;
    logic dup;
  } scan_stat_t;

endpackage

### hdl/suks_cell.sv
// One cell of the key chain: holds one key, compares, shifts with its neighbours.
module suks_cell #(
  parameter int KEY_WIDTH = suks_pkg::KEY_WIDTH_DEF
) (
  input  logic                 clk,
  input  suks_pkg::cell_op_t   op,
  input  logic [KEY_WIDTH-1:0] new_key,
  input  logic                 valid,
  input  logic [KEY_WIDTH-1:0] left_key,
  input  logic                 left_gt,
  input  logic [KEY_WIDTH-1:0] right_key,
  output logic [KEY_WIDTH-1:0] key,
  output logic                 gt,
  output logic                 eq
);
  import suks_pkg::*;

  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 gt_r, gt_nxt;

  assign eq = valid && (key_r == new_key);

  always_comb begin
    key_nxt = key_r;
    gt_nxt  = gt_r;
    unique case (op)
      CELL_HOLD: ;
      CELL_CMP:  gt_nxt = valid && (key_r > new_key);
      // Larger keys stay, the boundary cell takes the new key, the rest move down one place.
      CELL_INS: begin
        if (!gt_r) key_nxt = left_gt ? new_key : left_key;
      end
      CELL_POP:  key_nxt = right_key;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    gt_r  <= gt_nxt;
  end

  assign key = key_r;
  assign gt  = gt_r;

endmodule

### hdl/suks_chain.sv
// Row of key cells held in descending order, largest key in cell zero.
module suks_chain #(
  parameter int CAPACITY  = suks_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = suks_pkg::KEY_WIDTH_DEF,
  parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  suks_pkg::cell_op_t   op,
  input  logic [KEY_WIDTH-1:0] new_key,
  input  logic [CNT_W-1:0]     count,
  output logic [KEY_WIDTH-1:0] head_key,
  output logic [CAPACITY-1:0]  eq
);
  import suks_pkg::*;

  logic [KEY_WIDTH-1:0] keys [CAPACITY];
  logic [CAPACITY-1:0]  gts;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_key, right_key;
    logic                 left_gt, valid;

    assign valid = CNT_W'(i) < count;

    if (i == 0) begin : g_first
      assign left_key = new_key;
      assign left_gt  = 1'b1;
    end else begin : g_inner
      assign left_key = keys[i-1];
      assign left_gt  = gts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_mid
      assign right_key = keys[i+1];
    end

    suks_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
      .clk       (clk),
      .op        (op),
      .new_key   (new_key),
      .valid     (valid),
      .left_key  (left_key),
      .left_gt   (left_gt),
      .right_key (right_key),
      .key       (keys[i]),
      .gt        (gts[i]),
      .eq        (eq[i])
    );
  end

  assign head_key = keys[0];

endmodule

### hdl/suks_dup_scan.sv
// Duplicate scanner: ORs the captured match flags a group of lanes per cycle.
module suks_dup_scan #(
  parameter int CAPACITY = suks_pkg::CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [CAPACITY-1:0]    flags,
  output suks_pkg::scan_stat_t   stat
);
  import suks_pkg::*;

  localparam int LANE   = (CAPACITY < SCAN_LANES) ? CAPACITY : SCAN_LANES;
  localparam int PASSES = (CAPACITY + LANE - 1) / LANE;
  localparam int SCAN_W = PASSES * LANE;
  localparam int PW     = (PASSES > 1) ? $clog2(PASSES) : 1;

  logic [SCAN_W-1:0] vec_r, vec_nxt, pad;
  logic [PW-1:0]     pass_r, pass_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              dup_r, dup_nxt;

  always_comb begin
    pad = '0;
    pad[CAPACITY-1:0] = flags;
  end

  always_comb begin
    vec_nxt  = vec_r;
    pass_nxt = pass_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dup_nxt  = dup_r;
    if (start) begin
      vec_nxt  = pad;
      pass_nxt = '0;
      busy_nxt = 1'b1;
      dup_nxt  = 1'b0;
    end else if (busy_r) begin
      dup_nxt  = dup_r | (|vec_r[LANE-1:0]);
      vec_nxt  = vec_r >> LANE;
      pass_nxt = pass_r + 1'b1;
      if (pass_r == PW'(PASSES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    vec_r  <= vec_nxt;
    pass_r <= pass_nxt;
    dup_r  <= dup_nxt;
  end

  assign stat.done = done_r;
  assign stat.dup  = dup_r;

endmodule

### hdl/sorted_unique_key_set.sv
// Top level of the sorted unique key set: control, result register and checks.
`include "sorted_unique_key_set_macros.svh"

// Keeps up to CAPACITY unique keys of KEY_WIDTH bits in a row of cells, largest key
// first. Each transaction on the input stream gives exactly one result. For an
// insert, the cells first compare the key, then a scanner ORs the match flags up to
// 32 cells per cycle to find a duplicate, and the cells shift the key in as the
// result is written. Input is taken only while no operation is in progress; a
// finished result waits in the output register. Stored keys need no clearing after
// reset, so the block is ready from the first cycle out of reset. Keys wider than
// KEY_WIDTH are cut to their low bits; action code three acts as a clear.
module sorted_unique_key_set #(
  parameter int CAPACITY  = suks_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = suks_pkg::KEY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] key_out, [38:32] count, [39] zero
  output logic [2:0]  out_tuser   // [2:0] status
);
  import suks_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [1:0]           act_r, act_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           out_status_r;
  logic [OUT_KEY_W-1:0] out_key_r;
  logic [COUNT_W-1:0]   out_count_r;

  logic                 post_vld;
  logic [2:0]           post_status;
  logic [KEY_WIDTH-1:0] post_key;
  logic [CNT_W-1:0]     post_count;

  logic                 in_accept, out_free, full, scan_start;
  cell_op_t             cell_op;
  logic [KEY_WIDTH-1:0] head_key;
  logic [CAPACITY-1:0]  eq;
  scan_stat_t           scan_stat;

  logic [KEY_WIDTH+IN_KEY_W-1:0] in_key_ext;
  logic [KEY_WIDTH+OUT_KEY_W-1:0] post_key_ext;
  logic [CNT_W+COUNT_W-1:0]       post_count_ext;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign full       = (count_r == CNT_W'(CAPACITY));
  assign in_key_ext = {{KEY_WIDTH{1'b0}}, in_tdata};

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    key_nxt     = key_r;
    count_nxt   = count_r;
    cell_op     = CELL_HOLD;
    scan_start  = 1'b0;
    post_vld    = 1'b0;
    post_status = ST_CLEARED;
    post_key    = '0;
    post_count  = count_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          act_nxt   = in_tuser;
          key_nxt   = in_key_ext[KEY_WIDTH-1:0];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (act_r) inside
          ACT_CLEAR, ACT_CLEAR_ALT: begin
            if (out_free) begin
              count_nxt   = '0;
              post_vld    = 1'b1;
              post_status = ST_CLEARED;
              post_count  = '0;
              state_nxt   = S_IDLE;
            end
          end
          ACT_EXTRACT: begin
            if (out_free) begin
              post_vld  = 1'b1;
              state_nxt = S_IDLE;
              if (count_r != '0) begin
                cell_op     = CELL_POP;
                count_nxt   = count_r - 1'b1;
                post_status = ST_EXTRACTED;
                post_key    = head_key;
                post_count  = count_r - 1'b1;
              end else begin
                post_status = ST_EMPTY;
                post_count  = '0;
              end
            end
          end
          default: begin
            // Latch per-cell compare results and hand the match flags to the scanner.
            cell_op    = CELL_CMP;
            scan_start = 1'b1;
            state_nxt  = S_SCAN;
          end
        endcase
      end
      S_SCAN: begin
        if (scan_stat.done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          post_vld  = 1'b1;
          state_nxt = S_IDLE;
          if (scan_stat.dup) begin
            post_status = ST_DUPLICATE;
          end else if (full) begin
            post_status = ST_FULL;
          end else begin
            cell_op     = CELL_INS;
            count_nxt   = count_r + 1'b1;
            post_status = ST_INSERTED;
            post_count  = count_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign post_key_ext   = {{OUT_KEY_W{1'b0}}, post_key};
  assign post_count_ext = {{COUNT_W{1'b0}}, post_count};
  assign out_valid_nxt  = post_vld || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r <= act_nxt;
    key_r <= key_nxt;
    if (post_vld) begin
      out_status_r <= post_status;
      out_key_r    <= post_key_ext[OUT_KEY_W-1:0];
      out_count_r  <= post_count_ext[COUNT_W-1:0];
    end
  end

  suks_chain #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH),
    .CNT_W     (CNT_W)
  ) u_chain (
    .clk      (clk),
    .op       (cell_op),
    .new_key  (key_r),
    .count    (count_r),
    .head_key (head_key),
    .eq       (eq)
  );

  suks_dup_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .flags (eq),
    .stat  (scan_stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_key_r};
  assign out_tuser  = out_status_r;

  `SUKS_ASSERT_IMPL(a_count_in_range, 1'b1, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `SUKS_ASSERT_NEXT(a_accept_to_exec, in_accept, state_r == S_EXEC, "accept did not start an operation")
  `SUKS_ASSERT_IMPL(a_scan_done_in_scan, scan_stat.done, state_r == S_SCAN, "scan finished outside scan state")
  `SUKS_ASSERT_NEXT(a_insert_bumps_count, post_vld && post_status == ST_INSERTED, count_r == $past(count_r) + 1'b1, "insert did not add one key")

endmodule
